// ----- sv/fbpa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, field widths and status codes for the fixed block pool allocator.
package fbpa_pkg;

  localparam int COUNT_W  = 16;
  localparam int BLK_W    = 11;
  localparam int GRANT_W  = 10;
  localparam int STATUS_W = 2;
  localparam int USE_W    = 11;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FREE_IGNORED = 2'd3;

  localparam logic [COUNT_W-1:0] ONE_BLOCK = 16'd1;

  typedef struct packed {
    logic               opcode;
    logic [COUNT_W-1:0] request_count;
    logic [BLK_W-1:0]   block_index;
    logic               null_block;
  } req_t;

  typedef struct packed {
    logic [GRANT_W-1:0]  granted_index;
    logic [STATUS_W-1:0] status;
    logic [USE_W-1:0]    blocks_in_use;
    logic [USE_W-1:0]    blocks_free;
  } rsp_t;

endpackage

// ----- sv/fixed_block_pool_allocator.sv -----
`timescale 1ns / 1ps
// Fixed block pool allocator: LIFO free list of next links kept in a synchronous RAM.
// Requests are handled one at a time: a request beat is accepted only in the idle state,
// and its result is registered at the end of the execute state, which is held while
// the previous result has not been taken. An allocate needs the registered read of the
// link RAM before the new list head is known.
// Reset: synchronous, active high; then a pass over every address rewrites the link RAM.
module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  fbpa_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fbpa_pkg::rsp_t rsp_data
);

  import fbpa_pkg::*;

  // Block addresses need IDX_W bits; a link also has to hold the "none"
  // marker, which is encoded as NUM_BLOCKS itself.
  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int LINK_W = $clog2(NUM_BLOCKS + 1);

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_BLOCKS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);

  // Controller states.
  localparam logic [1:0] S_INIT = 2'd0;  // rewriting the link RAM after reset
  localparam logic [1:0] S_IDLE = 2'd1;  // waiting for a request beat
  localparam logic [1:0] S_EXEC = 2'd2;  // link read is back, update state

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [IDX_W-1:0]  init_addr;
  logic [LINK_W-1:0] list_head;
  logic [LINK_W-1:0] list_head_next;
  logic [LINK_W-1:0] in_use_count;
  logic [LINK_W-1:0] in_use_count_next;
  req_t              item;
  rsp_t              rsp_next;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [LINK_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [LINK_W-1:0] ram_rd_data;

  logic              accept;
  logic              exec_done;
  logic              alloc_ok;
  logic              free_ok;
  logic              index_in_pool;
  logic [IDX_W-1:0]  free_idx;
  logic [LINK_W-1:0] popped_link;

  fbpa_link_ram #(
    .DEPTH  (NUM_BLOCKS),
    .ADDR_W (IDX_W),
    .DATA_W (LINK_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (list_head[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // The link of the current head is fetched on the accept beat, so it is
  // on the RAM output during the execute cycle. The head cannot change in
  // between, and any free writes back in its execute cycle, before the next
  // accept can issue a read, so no forwarding path is needed. When the list
  // is empty the truncated address reads a harmless entry.
  assign ram_rd_en = accept;

  // An execute cycle finishes only when the output register has room.
  assign exec_done = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  // Request decode. With a pool larger than the index field every index
  // is inside the pool, so the compare runs at 32 bits.
  assign index_in_pool = {21'd0, item.block_index} < 32'(NUM_BLOCKS);
  assign free_idx      = IDX_W'(item.block_index);
  assign alloc_ok      = (item.opcode == OP_ALLOC) && (item.request_count == ONE_BLOCK)
                         && (list_head < LINK_NONE);
  assign free_ok       = (item.opcode == OP_FREE) && !item.null_block
                         && (item.request_count == ONE_BLOCK) && index_in_pool;

  // Links only ever hold values up to the "none" marker; the clamp keeps
  // the head legal regardless.
  assign popped_link = (ram_rd_data > LINK_NONE) ? LINK_NONE : ram_rd_data;

  // The RAM write port serves the reset pass and the push of a freed block,
  // which links the freed block to the old head.
  always_comb begin
    if (state == S_INIT) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = init_addr;
      ram_wr_data = LINK_W'(init_addr) + LINK_W'(1);
    end else begin
      ram_wr_en   = exec_done && free_ok;
      ram_wr_addr = free_idx;
      ram_wr_data = list_head;
    end
  end

  // Head, count and result for the item in execution.
  always_comb begin
    list_head_next    = list_head;
    in_use_count_next = in_use_count;
    rsp_next          = '0;
    if (item.opcode == OP_ALLOC) begin
      if (item.request_count != ONE_BLOCK) begin
        rsp_next.status = ST_BAD_COUNT;
      end else if (!alloc_ok) begin
        rsp_next.status = ST_EXHAUSTED;
      end else begin
        list_head_next         = popped_link;
        rsp_next.granted_index = GRANT_W'(list_head);
        rsp_next.status        = ST_OK;
        if (in_use_count < LINK_NONE) begin
          in_use_count_next = in_use_count + LINK_W'(1);
        end
      end
    end else begin
      if (free_ok) begin
        list_head_next  = LINK_W'(free_idx);
        rsp_next.status = ST_OK;
        // A double free is not detected; the count just stops at zero.
        if (in_use_count != '0) begin
          in_use_count_next = in_use_count - LINK_W'(1);
        end
      end else begin
        rsp_next.status = ST_FREE_IGNORED;
      end
    end
    rsp_next.blocks_in_use = USE_W'(in_use_count_next);
    rsp_next.blocks_free   = USE_W'(LINK_NONE - in_use_count_next);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (init_addr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      init_addr    <= '0;
      list_head    <= '0;
      in_use_count <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        init_addr <= init_addr + IDX_W'(1);
      end
      if (exec_done) begin
        list_head    <= list_head_next;
        in_use_count <= in_use_count_next;
        rsp_valid    <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req_data;
    end
    if (exec_done) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

// ----- sv/fbpa_link_ram.sv -----
`timescale 1ns / 1ps
// Next-link memory: one write port, one read port with registered read data.
module fbpa_link_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/fbpa_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the fixed block pool allocator, bound to the top level.
module fbpa_checker #(
  parameter int NUM_BLOCKS = 1024
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input fbpa_pkg::req_t req_data,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input fbpa_pkg::rsp_t rsp_data
);

  import fbpa_pkg::*;

  localparam logic [USE_W-1:0] POOL_MASKED = USE_W'(NUM_BLOCKS);

  // Requests are handled one at a time: an accepted beat closes the port.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request port stayed open after an accepted beat");

  // The link RAM rewrite keeps the request port closed right after reset.
  a_closed_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !req_ready)
    else $error("request port open during the reset pass");

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> USE_W'(rsp_data.blocks_in_use + rsp_data.blocks_free) == POOL_MASKED)
    else $error("blocks in use and blocks free do not add up to the pool size");

  a_no_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |-> rsp_data.granted_index == '0)
    else $error("granted index nonzero on a failed request");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response beat dropped or changed while stalled");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_fbpa_checker (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the fixed block pool allocator, with a free-list predictor.
module testbench;
  import fbpa_pkg::*;

  localparam int NUM_BLOCKS = 1024;
  // Limit on a stretch without any accepted beat before the run is declared hung. It
  // is set against the clearing pass after reset and the long receiver hold-off, so
  // that it is several times the worst quiet stretch of a good run.
  localparam int QUIET_LIMIT = 6000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  // Shadow of the free list. Every accepted request beat is run through the same
  // pop and push rules as the block, and the expected response beat is queued.
  class pool_tracker;
    logic [BLK_W-1:0] next_link [NUM_BLOCKS];
    logic [BLK_W-1:0] head;
    logic [USE_W-1:0] in_use;
    rsp_t             expected_rsp [$];
    int               mismatches;
    int               printed;

    function new();
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        next_link[i] = BLK_W'(i + 1);
      end
      head = '0;
      in_use = '0;
      mismatches = 0;
      printed = 0;
    endfunction

    function rsp_t note_request(req_t r);
      rsp_t o;
      o = '0;
      if (r.opcode == OP_ALLOC) begin
        if (r.request_count != ONE_BLOCK) begin
          o.status = ST_BAD_COUNT;
        end else if (int'(head) >= NUM_BLOCKS) begin
          o.status = ST_EXHAUSTED;
        end else begin
          o.granted_index = head[GRANT_W-1:0];
          head = next_link[head];
          if (int'(head) > NUM_BLOCKS) begin
            head = BLK_W'(NUM_BLOCKS);
          end
          if (int'(in_use) < NUM_BLOCKS) begin
            in_use = in_use + 1'b1;
          end
          o.status = ST_OK;
        end
      end else if (r.null_block || r.request_count != ONE_BLOCK ||
                   int'(r.block_index) >= NUM_BLOCKS) begin
        o.status = ST_FREE_IGNORED;
      end else begin
        next_link[r.block_index] = head;
        head = r.block_index;
        if (in_use != '0) begin
          in_use = in_use - 1'b1;
        end
        o.status = ST_OK;
      end
      o.blocks_in_use = in_use;
      o.blocks_free = USE_W'(NUM_BLOCKS - int'(in_use));
      expected_rsp.insert(expected_rsp.size(), o);
      return o;
    endfunction

    task report(string msg);
      mismatches++;
      if (printed < 40) begin
        printed++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
    endtask

    task check_response(rsp_t got);
      rsp_t exp;
      if (expected_rsp.size() == 0) begin
        report($sformatf("response beat with no request pending: %p", got));
      end else begin
        exp = expected_rsp.pop_front();
        if (got.granted_index !== exp.granted_index) begin
          report($sformatf("granted_index got %0d exp %0d", got.granted_index,
                           exp.granted_index));
        end
        if (got.status !== exp.status) begin
          report($sformatf("status got %0d exp %0d", got.status, exp.status));
        end
        if (got.blocks_in_use !== exp.blocks_in_use) begin
          report($sformatf("blocks_in_use got %0d exp %0d", got.blocks_in_use,
                           exp.blocks_in_use));
        end
        if (got.blocks_free !== exp.blocks_free) begin
          report($sformatf("blocks_free got %0d exp %0d", got.blocks_free,
                           exp.blocks_free));
        end
      end
    endtask
  endclass

  // All block inputs start from known values.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  pool_tracker tracker = new();

  // Blocks the stimulus believes are allocated; a multiset, since a double free
  // can make the list hand the same block out more than once.
  int   held [$];
  int   exhausted_seen = 0;
  bit   hold_off_req = 1'b0;
  bit   no_gaps = 1'b0;

  fixed_block_pool_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  always #5 clk = ~clk;

  function automatic req_t make_req(logic op, logic [COUNT_W-1:0] cnt,
                                    logic [BLK_W-1:0] idx, logic nul);
    req_t r;
    r.opcode = op;
    r.request_count = cnt;
    r.block_index = idx;
    r.null_block = nul;
    return r;
  endfunction

  function automatic req_t alloc_one();
    return make_req(OP_ALLOC, ONE_BLOCK, BLK_W'($urandom_range(0, 2047)),
                    1'($urandom_range(0, 1)));
  endfunction

  function automatic req_t free_block(int idx);
    return make_req(OP_FREE, ONE_BLOCK, BLK_W'(idx), 1'b0);
  endfunction

  // Malformed or ignored requests. A stray free of an arbitrary in-range block is
  // a possible double free, which can close a loop in the list, so it is kept out
  // of the fill phase where the pool has to run dry.
  function automatic req_t noise_req(bit allow_stray);
    logic [COUNT_W-1:0] cnt;
    int                 pick;
    cnt = COUNT_W'($urandom_range(0, 65535));
    pick = $urandom_range(0, allow_stray ? 4 : 3);
    case (pick)
      0: begin
        if (cnt == ONE_BLOCK) begin
          cnt = '0;
        end
        return make_req(OP_ALLOC, cnt, BLK_W'($urandom_range(0, 2047)),
                        1'($urandom_range(0, 1)));
      end
      1: begin
        return make_req(OP_FREE, cnt, BLK_W'($urandom_range(0, 2047)), 1'b1);
      end
      2: begin
        if (cnt == ONE_BLOCK) begin
          cnt = COUNT_W'(16'hFFFF);
        end
        return make_req(OP_FREE, cnt, BLK_W'($urandom_range(0, NUM_BLOCKS - 1)), 1'b0);
      end
      3: begin
        return make_req(OP_FREE, ONE_BLOCK, BLK_W'($urandom_range(NUM_BLOCKS, 2047)),
                        1'b0);
      end
      default: begin
        return free_block($urandom_range(0, NUM_BLOCKS - 1));
      end
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offers one request beat and waits for it to be taken. Valid is left high so
  // that back-to-back beats never lower and raise it within one time step.
  task automatic send_req(input req_t r);
    rsp_t p;
    int   gap;
    req_data <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
    p = tracker.note_request(r);
    if (p.status == ST_EXHAUSTED) begin
      exhausted_seen++;
    end
    if (p.status == ST_OK && r.opcode == OP_ALLOC) begin
      held.insert(held.size(), int'(p.granted_index));
    end else if (p.status == ST_OK) begin
      for (int k = 0; k < held.size(); k++) begin
        if (held[k] == int'(r.block_index)) begin
          held.delete(k);
          break;
        end
      end
    end
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic free_some_held();
    int k;
    k = $urandom_range(0, held.size() - 1);
    send_req(free_block(held[k]));
  endtask

  // Lets every queued expectation drain before going on.
  task automatic wait_all_answered();
    req_valid <= 1'b0;
    while (tracker.expected_rsp.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Response side: every beat taken goes straight to the checker.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      tracker.check_response(rsp_data);
    end
  end

  // Receiver backpressure in runs of random length. On request it holds off for a
  // long stretch so that the block fills up and has to stall its request side.
  initial begin
    int r;
    int run;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          rsp_ready <= 1'b1;
          run = $urandom_range(50, 150);
        end else if (r < 65) begin
          rsp_ready <= 1'b1;
          run = $urandom_range(1, 20);
        end else if (r < 93) begin
          rsp_ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          rsp_ready <= 1'b0;
          run = $urandom_range(10, 40);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  // Watchdog: a run in which neither side moves a beat for too long has hung.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int n;
    int r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: bad counts on allocate, every reason for an ignored free,
    // and LIFO reuse of freed blocks. Only blocks actually held are freed here, so
    // the list stays a clean chain for the fill phase.
    no_gaps = 1'b1;
    send_req(make_req(OP_ALLOC, '0, '0, 1'b0));
    send_req(make_req(OP_ALLOC, 16'hFFFF, 11'h7FF, 1'b1));
    send_req(make_req(OP_ALLOC, 16'd2, '0, 1'b0));
    send_req(alloc_one());
    send_req(alloc_one());
    send_req(alloc_one());
    no_gaps = 1'b0;
    send_req(make_req(OP_FREE, ONE_BLOCK, 11'd1, 1'b1));
    send_req(make_req(OP_FREE, '0, 11'd1, 1'b0));
    send_req(make_req(OP_FREE, 16'hFFFF, 11'd1, 1'b0));
    send_req(make_req(OP_FREE, ONE_BLOCK, BLK_W'(NUM_BLOCKS), 1'b0));
    send_req(make_req(OP_FREE, ONE_BLOCK, 11'h7FF, 1'b0));
    send_req(free_block(1));
    send_req(alloc_one());
    send_req(free_block(2));
    send_req(free_block(0));
    send_req(alloc_one());
    send_req(alloc_one());
    send_req(alloc_one());

    // Fill phase: mostly allocates, until the pool has been found empty several
    // times. Early on the receiver stops for a long while and the sender keeps
    // offering back to back, so the block backs up into its request side.
    n = 0;
    while (exhausted_seen < 8 && n < 4000) begin
      if (n == 150) begin
        hold_off_req = 1'b1;
        no_gaps = 1'b1;
      end else if (n == 200) begin
        no_gaps = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 90) begin
        send_req(alloc_one());
      end else if (r < 94 && held.size() != 0) begin
        free_some_held();
      end else begin
        send_req(noise_req(1'b0));
      end
      n++;
    end

    // Sender pauses with everything answered, then works the full pool: the top
    // and bottom blocks come back first, and a double free loops the list onto
    // itself so that the in-use count saturates at the pool size.
    wait_all_answered();
    send_req(alloc_one());
    send_req(free_block(NUM_BLOCKS - 1));
    send_req(alloc_one());
    send_req(free_block(0));
    send_req(alloc_one());
    send_req(free_block(5));
    send_req(free_block(5));
    repeat (4) send_req(alloc_one());

    // Mixed phase: allocates and frees of held blocks with random content, plus
    // malformed requests and stray frees that may hit a block already free.
    for (int i = 0; i < 400; i++) begin
      if (i == 200) begin
        wait_all_answered();
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_req(alloc_one());
      end else if (r < 82 && held.size() != 0) begin
        free_some_held();
      end else begin
        send_req(noise_req(1'b1));
      end
    end

    // Drain: hand back every held block, then free past zero so that the in-use
    // count saturates at the bottom.
    while (held.size() != 0) begin
      free_some_held();
    end
    send_req(free_block($urandom_range(0, NUM_BLOCKS - 1)));
    send_req(free_block($urandom_range(0, NUM_BLOCKS - 1)));
    send_req(alloc_one());

    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.expected_rsp.size() != 0) begin
      tracker.report("expected response beats left over at the end");
    end
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/fbpa_pkg.sv
sv/fbpa_link_ram.sv
sv/fixed_block_pool_allocator.sv
sv/fbpa_checker.sv
dv/testbench.sv
